FILE: design/cdb_pkg.sv
// Shared types and constants for the circular deque buffer.
package cdb_pkg;

  localparam int unsigned DepthDef   = 16;
  localparam int unsigned CapW       = 5;
  localparam int unsigned ValW       = 32;
  localparam logic [CapW-1:0] CapReset  = 5'd16;
  localparam logic [ValW-1:0] EmptyMark = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    FUNC_PUSH_FRONT = 2'd0,
    FUNC_PUSH_REAR  = 2'd1,
    FUNC_POP_FRONT  = 2'd2,
    FUNC_POP_REAR   = 2'd3
  } func_e;

  typedef struct packed {
    logic is_empty;
    logic is_full;
    logic rejected;
  } flags_t;

endpackage

FILE: design/cdb_store.sv
// Element store: one write port, two registered read ports.
module cdb_store #(
  parameter int unsigned Depth = cdb_pkg::DepthDef,
  parameter int unsigned IdxW  = $clog2(Depth)
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [IdxW-1:0]          waddr_i,
  input  logic [cdb_pkg::ValW-1:0] wdata_i,
  input  logic                     re_i,
  input  logic [IdxW-1:0]          raddr_a_i,
  input  logic [IdxW-1:0]          raddr_b_i,
  output logic [cdb_pkg::ValW-1:0] rdata_a_o,
  output logic [cdb_pkg::ValW-1:0] rdata_b_o
);
  import cdb_pkg::*;

  logic [ValW-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

FILE: design/cdb_ctrl.sv
// Index and occupancy update, sequencing and result register.
module cdb_ctrl #(
  parameter int unsigned Depth = cdb_pkg::DepthDef,
  parameter int unsigned IdxW  = $clog2(Depth),
  parameter int unsigned CntW  = (cdb_pkg::CapW > $clog2(Depth + 1)) ?
                                 cdb_pkg::CapW : $clog2(Depth + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [CntW-1:0]          cap_i,
  input  logic                     clr_i,
  output logic                     idle_o,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               func_i,
  input  logic [cdb_pkg::ValW-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [cdb_pkg::ValW-1:0] front_value_o,
  output logic [cdb_pkg::ValW-1:0] rear_value_o,
  output cdb_pkg::flags_t          flags_o,
  output logic                     we_o,
  output logic [IdxW-1:0]          waddr_o,
  output logic [cdb_pkg::ValW-1:0] wdata_o,
  output logic                     re_o,
  output logic [IdxW-1:0]          raddr_a_o,
  output logic [IdxW-1:0]          raddr_b_o,
  input  logic [cdb_pkg::ValW-1:0] rdata_a_i,
  input  logic [cdb_pkg::ValW-1:0] rdata_b_i
);
  import cdb_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e          st_q, st_d;
  logic [IdxW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0] occ_q, occ_d;
  flags_t          flags_q, flags_d;
  logic            accept, load_out;
  logic            out_valid_q;
  logic [ValW-1:0] front_q, rear_q;
  flags_t          out_flags_q;

  function automatic logic [IdxW-1:0] step_fwd(input logic [IdxW-1:0] i,
                                               input logic [CntW-1:0] cap);
    logic [CntW-1:0] nxt;
    nxt = CntW'(i) + CntW'(1);
    return (nxt >= cap) ? '0 : nxt[IdxW-1:0];
  endfunction

  function automatic logic [IdxW-1:0] step_back(input logic [IdxW-1:0] i,
                                                input logic [CntW-1:0] cap);
    logic [CntW-1:0] last;
    last = cap - CntW'(1);
    return (i == '0 || CntW'(i) >= cap) ? last[IdxW-1:0] : i - IdxW'(1);
  endfunction

  assign idle_o     = (st_q == ST_IDLE);
  assign in_ready_o = (st_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign wdata_o    = value_i;
  assign load_out   = (st_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    occ_d    = occ_q;
    we_o     = 1'b0;
    waddr_o  = '0;
    flags_d  = flags_q;
    flags_d.rejected = 1'b0;
    if (accept) begin
      unique case (func_e'(func_i))
        FUNC_PUSH_FRONT, FUNC_PUSH_REAR: begin
          if (occ_q >= cap_i) begin
            flags_d.rejected = 1'b1;
          end else if (occ_q == '0) begin
            head_d  = '0;
            tail_d  = '0;
            we_o    = 1'b1;
            waddr_o = '0;
            occ_d   = CntW'(1);
          end else if (func_e'(func_i) == FUNC_PUSH_FRONT) begin
            head_d  = step_back(head_q, cap_i);
            we_o    = 1'b1;
            waddr_o = head_d;
            occ_d   = occ_q + CntW'(1);
          end else begin
            tail_d  = step_fwd(tail_q, cap_i);
            we_o    = 1'b1;
            waddr_o = tail_d;
            occ_d   = occ_q + CntW'(1);
          end
        end
        FUNC_POP_FRONT, FUNC_POP_REAR: begin
          if (occ_q == '0) begin
            flags_d.rejected = 1'b1;
          end else if (occ_q == CntW'(1)) begin
            head_d = '0;
            tail_d = '0;
            occ_d  = '0;
          end else if (func_e'(func_i) == FUNC_POP_FRONT) begin
            head_d = step_fwd(head_q, cap_i);
            occ_d  = occ_q - CntW'(1);
          end else begin
            tail_d = step_back(tail_q, cap_i);
            occ_d  = occ_q - CntW'(1);
          end
        end
        default: ;
      endcase
      flags_d.is_empty = (occ_d == '0);
      flags_d.is_full  = (occ_d >= cap_i);
    end
    if (clr_i) begin
      head_d = '0;
      tail_d = '0;
      occ_d  = '0;
    end
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: if (accept) begin
        st_d = ST_READ;
      end
      ST_READ: st_d = ST_DONE;
      ST_DONE: if (load_out) begin
        st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  assign re_o      = (st_q == ST_READ);
  assign raddr_a_o = head_q;
  assign raddr_b_o = tail_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      head_q <= head_d;
      tail_q <= tail_d;
      occ_q  <= occ_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      flags_q <= flags_d;
    end
    if (load_out) begin
      front_q     <= flags_q.is_empty ? EmptyMark : rdata_a_i;
      rear_q      <= flags_q.is_empty ? EmptyMark : rdata_b_i;
      out_flags_q <= flags_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign front_value_o = front_q;
  assign rear_value_o  = rear_q;
  assign flags_o       = out_flags_q;

endmodule

FILE: design/circular_deque_buffer_top.sv
// Circular deque buffer top level: capacity register, controller and store.
// After acceptance, a request passes the store read and then the result load;
// the load waits while an earlier result is still held in the result register.
// One request is handled at a time; a new one is taken while a result waits.
// Reset: empty deque, capacity 16; store contents are undefined until written.
// A capacity write empties the deque.
module circular_deque_buffer_top #(
  parameter int unsigned DEPTH = cdb_pkg::DepthDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [cdb_pkg::CapW-1:0] capacity_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               func_i,
  input  logic signed [cdb_pkg::ValW-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [cdb_pkg::ValW-1:0] front_value_o,
  output logic signed [cdb_pkg::ValW-1:0] rear_value_o,
  output logic                     is_empty_o,
  output logic                     is_full_o,
  output logic                     rejected_o
);
  import cdb_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = (CapW > $clog2(DEPTH + 1)) ? CapW : $clog2(DEPTH + 1);

  logic [CapW-1:0] cap_q;
  logic [CntW-1:0] cap_nz, cap_eff;
  logic            cfg_fire, idle;
  flags_t          flags;
  logic            we, re;
  logic [IdxW-1:0] waddr, raddr_a, raddr_b;
  logic [ValW-1:0] wdata, rdata_a, rdata_b, front_u, rear_u;

  // a pending request goes first
  assign cfg_ready_o = idle && !in_valid_i;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (cfg_fire) begin
      cap_q <= capacity_i;
    end
  end

  assign cap_nz  = (cap_q == '0) ? CntW'(1) : CntW'(cap_q);
  assign cap_eff = (cap_nz > CntW'(DEPTH)) ? CntW'(DEPTH) : cap_nz;

  cdb_ctrl #(
    .Depth (DEPTH),
    .IdxW  (IdxW),
    .CntW  (CntW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cap_i         (cap_eff),
    .clr_i         (cfg_fire),
    .idle_o        (idle),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .front_value_o (front_u),
    .rear_value_o  (rear_u),
    .flags_o       (flags),
    .we_o          (we),
    .waddr_o       (waddr),
    .wdata_o       (wdata),
    .re_o          (re),
    .raddr_a_o     (raddr_a),
    .raddr_b_o     (raddr_b),
    .rdata_a_i     (rdata_a),
    .rdata_b_i     (rdata_b)
  );

  cdb_store #(
    .Depth (DEPTH),
    .IdxW  (IdxW)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .re_i      (re),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  assign front_value_o = front_u;
  assign rear_value_o  = rear_u;
  assign is_empty_o    = flags.is_empty;
  assign is_full_o     = flags.is_full;
  assign rejected_o    = flags.rejected;

endmodule

FILE: sim/tb_circular_deque_buffer_top.sv
// Testbench for the circular deque buffer: directed and random deque requests checked against a shadow deque.
`timescale 1ns / 100ps

module tb_circular_deque_buffer_top;
  import cdb_pkg::*;

  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned MaxReports    = 10;
  localparam int unsigned HoldCycles    = 80;
  localparam int unsigned PhaseCount    = 11;
  localparam int unsigned PhaseHalf     = 20;

  typedef struct packed {
    logic [ValW-1:0] front;
    logic [ValW-1:0] rear;
    flags_t          flags;
  } deque_view_t;

  class deque_shadow;
    logic [ValW-1:0] slots [DepthDef];
    int unsigned     head;
    int unsigned     tail;
    int unsigned     occ;
    logic [CapW-1:0] cap_reg;
    deque_view_t     pending_views [$];
    int unsigned     fails;

    function new();
      foreach (slots[i]) slots[i] = '0;
      cap_reg = CapReset;
      head    = 0;
      tail    = 0;
      occ     = 0;
      fails   = 0;
    endfunction

    function void load_capacity(logic [CapW-1:0] c);
      cap_reg = c;
      head    = 0;
      tail    = 0;
      occ     = 0;
    endfunction

    function int unsigned entries_in_use();
      int unsigned c;
      c = cap_reg;
      if (c == 0) c = 1;
      if (c > DepthDef) c = DepthDef;
      return c;
    endfunction

    function void take_request(func_e f, logic [ValW-1:0] v);
      int unsigned cap;
      deque_view_t view;
      cap = entries_in_use();
      view.flags.rejected = 1'b0;
      if (f == FUNC_PUSH_FRONT || f == FUNC_PUSH_REAR) begin
        if (occ >= cap) begin
          view.flags.rejected = 1'b1;
        end else if (occ == 0) begin
          head     = 0;
          tail     = 0;
          slots[0] = v;
          occ      = 1;
        end else if (f == FUNC_PUSH_FRONT) begin
          head = (head == 0 || head >= cap) ? cap - 1 : head - 1;
          slots[head % DepthDef] = v;
          occ++;
        end else begin
          tail = (tail + 1 >= cap) ? 0 : tail + 1;
          slots[tail % DepthDef] = v;
          occ++;
        end
      end else begin
        if (occ == 0) begin
          view.flags.rejected = 1'b1;
        end else if (occ == 1) begin
          head = 0;
          tail = 0;
          occ  = 0;
        end else if (f == FUNC_POP_FRONT) begin
          head = (head + 1 >= cap) ? 0 : head + 1;
          occ--;
        end else begin
          tail = (tail == 0 || tail >= cap) ? cap - 1 : tail - 1;
          occ--;
        end
      end
      view.front          = (occ == 0) ? EmptyMark : slots[head % DepthDef];
      view.rear           = (occ == 0) ? EmptyMark : slots[tail % DepthDef];
      view.flags.is_empty = (occ == 0);
      view.flags.is_full  = (occ >= cap);
      pending_views.push_back(view);
    endfunction

    function void check_view(deque_view_t got);
      deque_view_t want;
      if (pending_views.size() == 0) begin
        fails++;
        if (fails <= MaxReports) begin
          $display("unexpected result: front %h rear %h empty %b full %b rejected %b",
                   got.front, got.rear, got.flags.is_empty, got.flags.is_full,
                   got.flags.rejected);
        end
        return;
      end
      want = pending_views.pop_front();
      if (got.front !== want.front || got.rear !== want.rear ||
          got.flags !== want.flags) begin
        fails++;
        if (fails <= MaxReports) begin
          $display("mismatch: front %h/%h rear %h/%h empty %b/%b full %b/%b rejected %b/%b",
                   want.front, got.front, want.rear, got.rear,
                   want.flags.is_empty, got.flags.is_empty,
                   want.flags.is_full, got.flags.is_full,
                   want.flags.rejected, got.flags.rejected);
        end
      end
    endfunction

    function int unsigned pending();
      return pending_views.size();
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CapW-1:0]        capacity_i;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic [1:0]             func_i;
  logic signed [ValW-1:0] value_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic signed [ValW-1:0] front_value_o;
  logic signed [ValW-1:0] rear_value_o;
  logic                   is_empty_o;
  logic                   is_full_o;
  logic                   rejected_o;

  deque_shadow shadow;
  bit          tx_idle;
  bit          rx_idle;
  bit          long_hold;
  int unsigned stall_cycles;

  circular_deque_buffer_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .capacity_i    (capacity_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .front_value_o (front_value_o),
    .rear_value_o  (rear_value_o),
    .is_empty_o    (is_empty_o),
    .is_full_o     (is_full_o),
    .rejected_o    (rejected_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WatchdogLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_req(input func_e f, input logic [ValW-1:0] v);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    func_i     = f;
    value_i    = v;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    shadow.take_request(f, v);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic wait_drained();
    while (shadow.pending() != 0) @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [CapW-1:0] c);
    wait_drained();
    repeat (4) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    capacity_i  = c;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    shadow.load_capacity(c);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // each run of twelve requests is randomly push-heavy or pop-heavy to reach full and empty
  task automatic run_random(input int unsigned n_items);
    int unsigned push_pct;
    func_e       f;
    push_pct = 50;
    for (int i = 0; i < n_items; i++) begin
      if (i % 12 == 0) push_pct = ($urandom_range(0, 1) != 0) ? 80 : 25;
      if ($urandom_range(0, 99) < push_pct) f = func_e'($urandom_range(0, 1));
      else f = func_e'($urandom_range(2, 3));
      send_req(f, $urandom());
    end
  endtask

  initial begin
    deque_view_t got;
    int unsigned gap;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      gap = rx_idle ? $urandom_range(0, 6) : 0;
      if (long_hold) begin
        gap       = HoldCycles;
        long_hold = 1'b0;
      end
      if (gap > 0) begin
        out_ready_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      got.front          = front_value_o;
      got.rear           = rear_value_o;
      got.flags.is_empty = is_empty_o;
      got.flags.is_full  = is_full_o;
      got.flags.rejected = rejected_o;
      shadow.check_view(got);
      @(negedge clk_i);
    end
  end

  initial begin
    logic [CapW-1:0] phase_caps [PhaseCount];
    logic [CapW-1:0] cap;
    phase_caps  = '{5'd1, 5'd3, 5'd16, 5'd5, 5'd31, 5'd2, 5'd17, 5'd0, 5'd8, 5'd0, 5'd0};
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    capacity_i  = '0;
    in_valid_i  = 1'b0;
    func_i      = FUNC_PUSH_FRONT;
    value_i     = '0;
    tx_idle     = 1'b1;
    rx_idle     = 1'b1;
    long_hold   = 1'b0;
    stall_cycles = 0;
    shadow      = new();
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset capacity: pops on empty, front push wrap, value extremes
    send_req(FUNC_POP_FRONT, 32'h0000_0000);
    send_req(FUNC_POP_REAR, 32'hFFFF_FFFF);
    send_req(FUNC_PUSH_FRONT, 32'h7FFF_FFFF);
    send_req(FUNC_PUSH_FRONT, 32'h8000_0000);
    send_req(FUNC_PUSH_REAR, 32'h0000_0000);
    send_req(FUNC_PUSH_REAR, 32'hFFFF_FFFF);
    send_req(FUNC_POP_FRONT, 32'h1234_5678);
    send_req(FUNC_POP_REAR, 32'h0000_0000);
    send_req(FUNC_POP_FRONT, 32'h0000_0000);
    send_req(FUNC_PUSH_REAR, 32'h5555_5555);
    // capacity write on a non-empty deque empties it
    write_capacity(5'd2);
    send_req(FUNC_PUSH_REAR, 32'hAAAA_AAAA);
    send_req(FUNC_PUSH_FRONT, 32'h5555_5555);
    send_req(FUNC_PUSH_REAR, 32'h0F0F_0F0F);
    send_req(FUNC_PUSH_FRONT, 32'hF0F0_F0F0);
    send_req(FUNC_POP_REAR, 32'h0000_0000);
    send_req(FUNC_POP_FRONT, 32'h0000_0000);
    send_req(FUNC_POP_REAR, 32'h0000_0000);
    // zero capacity acts as one entry
    write_capacity(5'd0);
    send_req(FUNC_PUSH_FRONT, 32'h0000_0001);
    send_req(FUNC_PUSH_REAR, 32'h0000_0002);
    send_req(FUNC_POP_REAR, 32'h0000_0000);
    send_req(FUNC_POP_FRONT, 32'h0000_0000);
    // oversized capacity saturates at the built depth
    write_capacity(5'd31);
    send_req(FUNC_PUSH_REAR, 32'h0000_0000);
    send_req(FUNC_PUSH_REAR, 32'h7FFF_FFFF);
    send_req(FUNC_POP_FRONT, 32'h0000_0000);

    for (int p = 0; p < PhaseCount; p++) begin
      cap = (p >= 9) ? CapW'($urandom_range(0, 31)) : phase_caps[p];
      write_capacity(cap);
      tx_idle = (p % 4 != 0);
      rx_idle = (p % 4 != 0) && ($urandom_range(0, 3) != 0);
      if (p == 2) begin
        tx_idle   = 1'b0;
        long_hold = 1'b1;
      end
      run_random(PhaseHalf);
      if (p == 5) wait_drained();
      run_random(PhaseHalf);
    end

    in_valid_i = 1'b0;
    wait_drained();
    repeat (10) @(negedge clk_i);
    if (shadow.fails == 0 && shadow.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/cdb_pkg.sv
design/cdb_store.sv
design/cdb_ctrl.sv
design/circular_deque_buffer_top.sv
sim/tb_circular_deque_buffer_top.sv
